// File: design/tcst_pkg.sv
package tcst_pkg;

  // Table size and register reset values
  localparam int DEF_NUM_CONNECTIONS = 16;
  localparam logic [31:0] DEF_INITIAL_SEQUENCE = 32'd100;
  localparam logic [15:0] DEF_MAX_SEGMENT = 16'd1460;
  localparam logic [15:0] DEF_ADVERTISED_WINDOW = 16'd500;

  // Opcodes
  localparam logic [2:0] OP_OPEN = 3'd0;
  localparam logic [2:0] OP_CONNECT = 3'd1;
  localparam logic [2:0] OP_SEND = 3'd2;
  localparam logic [2:0] OP_RECV = 3'd3;
  localparam logic [2:0] OP_CLOSE = 3'd4;
  localparam logic [2:0] OP_TICK = 3'd5;

  // Result codes
  localparam logic [3:0] RC_OK = 4'd0;
  localparam logic [3:0] RC_NO_FREE = 4'd1;
  localparam logic [3:0] RC_WRONG_STATE = 4'd2;
  localparam logic [3:0] RC_NO_MATCH = 4'd3;
  localparam logic [3:0] RC_UNEXP_SYN = 4'd4;
  localparam logic [3:0] RC_DUPLICATE = 4'd5;
  localparam logic [3:0] RC_OUT_OF_ORDER = 4'd6;
  localparam logic [3:0] RC_ACK_RANGE = 4'd7;
  localparam logic [3:0] RC_IGNORED = 4'd8;

  // Connection states
  localparam logic [1:0] ST_CLOSED = 2'd0;
  localparam logic [1:0] ST_RESERVED = 2'd1;
  localparam logic [1:0] ST_SYNSENT = 2'd2;
  localparam logic [1:0] ST_ESTAB = 2'd3;

  // Segment flags
  localparam logic [3:0] FL_SYN = 4'd1;
  localparam logic [3:0] FL_ACK = 4'd2;
  localparam logic [3:0] FL_FIN = 4'd4;
  localparam logic [3:0] FL_PSH = 4'd8;

  // Configuration register indexes
  localparam logic [1:0] CFG_INIT_SEQ = 2'd0;
  localparam logic [1:0] CFG_MAX_SEG = 2'd1;
  localparam logic [1:0] CFG_ADV_WIN = 2'd2;

  // Per-slot connection record held in the table memory
  typedef struct packed {
    logic [31:0] own_address;
    logic [31:0] peer_address;
    logic [15:0] own_port;
    logic [15:0] peer_port;
    logic [31:0] send_unacked;
    logic [31:0] send_next;
    logic [31:0] send_current;
    logic [31:0] receive_next;
    logic [15:0] last_send_length;
  } conn_rec_t;

endpackage

// File: design/tcst_slot_mem.sv
module tcst_slot_mem
  import tcst_pkg::*;
#(
  parameter int NUM_CONNECTIONS = DEF_NUM_CONNECTIONS,
  localparam int IW = (NUM_CONNECTIONS > 1) ? $clog2(NUM_CONNECTIONS) : 1
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [IW-1:0]   wr_addr,
  input  conn_rec_t       wr_data,
  input  logic            rd_en,
  input  logic [IW-1:0]   rd_addr,
  output conn_rec_t       rd_data
);

  conn_rec_t mem [NUM_CONNECTIONS];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: design/tcp_connection_state_tracker_top.sv
// TCP connection table with one result item per input item. Slot records live
// in a single-port-read memory with a registered read port; slot states sit
// in flip-flops cleared by reset, so no clearing pass is needed and the block
// accepts items right after reset. Connect, send, close and tick step through
// read, check, execute and back to idle, or go straight to execute for a slot
// out of range. Open scans slot states one per cycle up to the last slot.
// Receive reads and compares one slot record at a time through the registered
// memory read port, up to every slot. A new item is taken while the previous
// result still waits in the output register; execution holds until it is taken.
module tcp_connection_state_tracker_top
  import tcst_pkg::*;
#(
  parameter int NUM_CONNECTIONS = DEF_NUM_CONNECTIONS
) (
  input  logic         clk,
  input  logic         rst_n,
  // opcode[2:0] slot[6:3] remote_address[38:7] local_address[70:39]
  // peer_tcp_port[86:71] own_tcp_port[102:87] seq_number[134:103]
  // ack_number[166:135] syn_flag[167] ack_flag[168] data_length[184:169]
  input  logic [191:0] in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // result_code[3:0] slot_out[7:4] segment_valid[8] segment_flags[12:9]
  // segment_seq[44:13] segment_ack[76:45] segment_src_port[92:77]
  // segment_dst_port[108:93] segment_length[124:109] segment_window[140:125]
  // connection_state[142:141]
  output logic [143:0] out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int IW = (NUM_CONNECTIONS > 1) ? $clog2(NUM_CONNECTIONS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_CONNECTIONS - 1);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_RD, S_CHK, S_EXEC} fsm_t;

  fsm_t        state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic        found_r, found_nxt;
  logic [191:0] item_r;
  logic [1:0]  slot_st_r [NUM_CONNECTIONS];
  logic [31:0] init_seq_r;
  logic [15:0] max_seg_r;
  logic [15:0] adv_win_r;
  logic        out_valid_r;
  logic [143:0] out_data_r;
  logic [143:0] out_data_nxt;

  // Unpack the held item
  logic [2:0]  i_op;
  logic [3:0]  i_slot;
  logic [31:0] i_raddr, i_laddr, i_seq, i_ack;
  logic [15:0] i_rport, i_lport, i_dlen;
  logic        i_syn, i_ackf;
  assign i_op    = item_r[2:0];
  assign i_slot  = item_r[6:3];
  assign i_raddr = item_r[38:7];
  assign i_laddr = item_r[70:39];
  assign i_rport = item_r[86:71];
  assign i_lport = item_r[102:87];
  assign i_seq   = item_r[134:103];
  assign i_ack   = item_r[166:135];
  assign i_syn   = item_r[167];
  assign i_ackf  = item_r[168];
  assign i_dlen  = item_r[184:169];

  // Slot record memory
  conn_rec_t rd_rec, wr_rec;
  logic      wr_en;

  tcst_slot_mem #(.NUM_CONNECTIONS(NUM_CONNECTIONS)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (idx_r),
    .wr_data (wr_rec),
    .rd_en   (state_r == S_RD),
    .rd_addr (idx_r),
    .rd_data (rd_rec)
  );

  logic out_free;
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  logic [1:0] cur_st;
  assign cur_st = slot_st_r[idx_r];

  // Receive match against the record just read
  logic rx_match;
  assign rx_match = (cur_st == ST_SYNSENT || cur_st == ST_ESTAB) &&
                    rd_rec.peer_address == i_raddr && rd_rec.own_address == i_laddr &&
                    rd_rec.peer_port == i_rport && rd_rec.own_port == i_lport;

  // Sequencer next state
  logic [2:0] a_op;
  logic [3:0] a_slot;
  logic       a_slot_ok;
  assign a_op      = in_tdata[2:0];
  assign a_slot    = in_tdata[6:3];
  assign a_slot_ok = 32'(a_slot) < NUM_CONNECTIONS;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    found_nxt = found_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          idx_nxt   = '0;
          found_nxt = 1'b0;
          case (a_op)
            OP_OPEN: state_nxt = S_SCAN;
            OP_RECV: state_nxt = S_RD;
            OP_CONNECT, OP_SEND, OP_CLOSE, OP_TICK: begin
              idx_nxt   = IW'(a_slot);
              found_nxt = a_slot_ok;
              state_nxt = a_slot_ok ? S_RD : S_EXEC;
            end
            default: state_nxt = S_EXEC;
          endcase
        end
      end
      S_SCAN: begin
        if (cur_st == ST_CLOSED) begin
          found_nxt = 1'b1;
          state_nxt = S_EXEC;
        end else if (idx_r == LAST_IDX) begin
          state_nxt = S_EXEC;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_RD: state_nxt = S_CHK;
      S_CHK: begin
        if (i_op != OP_RECV || rx_match) begin
          found_nxt = (i_op == OP_RECV) ? 1'b1 : found_r;
          state_nxt = S_EXEC;
        end else if (idx_r == LAST_IDX) begin
          state_nxt = S_EXEC;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_EXEC: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Execute one operation on the selected slot
  logic [3:0]  x_code, x_flags;
  logic        x_emit, x_st_we;
  logic [1:0]  x_st;
  logic [15:0] x_len, mss, snd_len;
  logic [31:0] x_seq, x_ack;
  logic [15:0] x_dport;
  logic [31:0] sel_ext;
  logic [3:0]  x_slot_out;
  logic [1:0]  x_cstate;
  conn_rec_t   r;

  assign mss     = (max_seg_r == 16'd0) ? 16'd1 : max_seg_r;
  assign snd_len = (i_dlen < mss) ? i_dlen : mss;
  assign sel_ext = 32'(idx_r);

  always_comb begin
    r       = rd_rec;
    x_code  = RC_IGNORED;
    x_flags = '0;
    x_emit  = 1'b0;
    x_len   = '0;
    x_st    = cur_st;
    x_st_we = 1'b0;
    wr_en   = 1'b0;
    x_seq   = rd_rec.send_current;
    x_ack   = rd_rec.receive_next;
    x_dport = rd_rec.peer_port;
    case (i_op)
      OP_OPEN: begin
        x_code = RC_NO_FREE;
        if (found_r) begin
          r             = '0;
          r.own_address = i_laddr;
          r.own_port    = i_lport;
          x_st          = ST_RESERVED;
          x_st_we       = 1'b1;
          wr_en         = 1'b1;
          x_code        = RC_OK;
        end
      end
      OP_CONNECT: begin
        if (found_r) begin
          if (cur_st != ST_RESERVED) begin
            x_code = RC_WRONG_STATE;
          end else begin
            r.peer_address = i_raddr;
            r.peer_port    = i_rport;
            r.send_unacked = init_seq_r;
            r.send_current = init_seq_r;
            r.send_next    = init_seq_r + 32'd1;
            x_st    = ST_SYNSENT;
            x_st_we = 1'b1;
            wr_en   = 1'b1;
            x_emit  = 1'b1;
            x_flags = FL_SYN;
            x_seq   = init_seq_r;
            x_dport = i_rport;
            x_code  = RC_OK;
          end
        end
      end
      OP_SEND: begin
        if (found_r) begin
          if (cur_st != ST_ESTAB) begin
            x_code = RC_WRONG_STATE;
          end else if (i_dlen != 16'd0) begin
            r.send_current     = rd_rec.send_next;
            r.send_next        = rd_rec.send_next + 32'(snd_len);
            r.last_send_length = snd_len;
            wr_en   = 1'b1;
            x_emit  = 1'b1;
            x_flags = FL_PSH | FL_ACK;
            x_seq   = rd_rec.send_next;
            x_len   = snd_len;
            x_code  = RC_OK;
          end
        end
      end
      OP_CLOSE: begin
        if (found_r) begin
          if (cur_st == ST_CLOSED) begin
            x_code = RC_WRONG_STATE;
          end else begin
            x_emit  = 1'b1;
            x_flags = FL_FIN;
            x_st    = ST_CLOSED;
            x_st_we = 1'b1;
            x_code  = RC_OK;
          end
        end
      end
      OP_TICK: begin
        if (found_r) begin
          if (cur_st == ST_SYNSENT) begin
            r.send_next    = rd_rec.send_current + 32'd1;
            r.send_unacked = rd_rec.send_current;
            wr_en   = 1'b1;
            x_emit  = 1'b1;
            x_flags = FL_SYN;
            x_code  = RC_OK;
          end else if (cur_st == ST_ESTAB) begin
            if (rd_rec.send_unacked < rd_rec.send_next) begin
              x_emit  = 1'b1;
              x_flags = FL_PSH | FL_ACK;
              x_len   = rd_rec.last_send_length;
              x_code  = RC_OK;
            end
          end else begin
            x_code = RC_WRONG_STATE;
          end
        end
      end
      OP_RECV: begin
        x_code = RC_NO_MATCH;
        if (found_r) begin
          if (cur_st == ST_SYNSENT) begin
            if (!(i_syn && i_ackf)) begin
              x_code = RC_IGNORED;
            end else if (rd_rec.send_unacked <= i_ack && i_ack <= rd_rec.send_next) begin
              r.send_unacked = i_ack;
              r.send_current = i_ack;
              r.send_next    = i_ack;
              r.receive_next = i_seq + 32'd1;
              x_st    = ST_ESTAB;
              x_st_we = 1'b1;
              wr_en   = 1'b1;
              x_emit  = 1'b1;
              x_flags = FL_ACK;
              x_seq   = i_ack;
              x_ack   = i_seq + 32'd1;
              x_code  = RC_OK;
            end else begin
              x_code = RC_ACK_RANGE;
            end
          end else begin
            // Advance the unacknowledged mark before the data checks
            if (i_ackf && rd_rec.send_unacked < i_ack && i_ack <= rd_rec.send_next) begin
              r.send_unacked = i_ack;
              wr_en = 1'b1;
            end
            if (i_syn) begin
              x_code = RC_UNEXP_SYN;
            end else if (!i_ackf && i_seq < rd_rec.receive_next) begin
              x_code = RC_DUPLICATE;
            end else if (rd_rec.receive_next == i_seq) begin
              r.receive_next = i_seq + 32'(i_dlen);
              wr_en   = 1'b1;
              x_emit  = 1'b1;
              x_flags = FL_ACK;
              x_ack   = i_seq + 32'(i_dlen);
              x_code  = RC_OK;
            end else begin
              x_code = RC_OUT_OF_ORDER;
            end
          end
        end
      end
      default: x_code = RC_IGNORED;
    endcase
    if (state_r != S_EXEC || !out_free) begin
      wr_en   = 1'b0;
      x_st_we = 1'b0;
    end
    wr_rec = r;
  end

  // Result fields
  always_comb begin
    x_slot_out = '0;
    x_cstate   = ST_CLOSED;
    if (i_op == OP_CONNECT || i_op == OP_SEND || i_op == OP_CLOSE || i_op == OP_TICK) begin
      x_slot_out = i_slot;
    end
    if (found_r) begin
      x_slot_out = sel_ext[3:0];
      x_cstate   = x_st;
    end
  end

  // Pack the result item; segment fields stay zero without a segment
  always_comb begin
    out_data_nxt          = '0;
    out_data_nxt[3:0]     = x_code;
    out_data_nxt[7:4]     = x_slot_out;
    out_data_nxt[142:141] = x_cstate;
    if (x_emit) begin
      out_data_nxt[8]       = 1'b1;
      out_data_nxt[12:9]    = x_flags;
      out_data_nxt[44:13]   = x_seq;
      out_data_nxt[76:45]   = x_ack;
      out_data_nxt[92:77]   = rd_rec.own_port;
      out_data_nxt[108:93]  = x_dport;
      out_data_nxt[124:109] = x_len;
      out_data_nxt[140:125] = adv_win_r;
    end
  end

  // Hold control state, configuration and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      init_seq_r  <= DEF_INITIAL_SEQUENCE;
      max_seg_r   <= DEF_MAX_SEGMENT;
      adv_win_r   <= DEF_ADVERTISED_WINDOW;
      for (int k = 0; k < NUM_CONNECTIONS; k++) slot_st_r[k] <= ST_CLOSED;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      found_r <= found_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_INIT_SEQ: init_seq_r <= cfg_data;
          CFG_MAX_SEG:  max_seg_r  <= cfg_data[15:0];
          CFG_ADV_WIN:  adv_win_r  <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (x_st_we) slot_st_r[idx_r] <= x_st;
      if (state_r == S_EXEC && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture item and result payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) item_r <= in_tdata;
    if (state_r == S_EXEC && out_free) out_data_r <= out_data_nxt;
  end

  // An accepted item keeps the input closed for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an item is in progress");

  // No segment means cleared segment fields
  a_noseg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[8]) |-> (out_tdata[140:9] == '0))
    else $error("segment fields set without a segment");

  // A failed receive match reports slot zero in closed state
  a_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[3:0] == RC_NO_MATCH) |->
      (out_tdata[7:4] == 4'd0 && out_tdata[142:141] == ST_CLOSED))
    else $error("no-match result carries a slot");

endmodule
